// ===== sv/adc_average_temperature_defines.svh =====
// Assertion macros shared by the averaging block's modules.
`ifndef ADC_AVERAGE_TEMPERATURE_DEFINES_SVH
`define ADC_AVERAGE_TEMPERATURE_DEFINES_SVH
`ifndef SYNTHESIS
`define AAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define AAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AAT_ASSERT(lbl, prop, msg)
`define AAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/aat_pkg.sv =====
// Package of shared widths and constants for the averaging block.
package aat_pkg;

    localparam int CNT_W   = 8;    // window length and sample count
    localparam int AVG_W   = 12;   // width of the reported average
    localparam int TEMP_W  = 16;   // width of the reported temperature
    localparam int FRAC_W  = 16;   // fraction bits of the fixed-point constants
    localparam int PROD_W  = 33;   // average times slope, any sample width
    localparam int ACC_W   = 35;   // signed offset minus product

    localparam logic [CNT_W-1:0] CNT_RESET = 8'd50;

    // round(2^16 * 100 * (1.43/0.0043 + 25))
    localparam logic [31:0] TEMP_K0 = 32'd2343293023;

endpackage

// ===== sv/aat_front.sv =====
// Front end: sample accumulation, window length register and window close.
module aat_front #(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [aat_pkg::CNT_W-1:0]  i_cfg_sample_count,
    output logic                       o_cfg_ready,
    input  logic                       i_push,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    output logic                       o_full,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output logic [SUM_W-1:0]           o_q_sum,
    output logic [aat_pkg::CNT_W-1:0]  o_q_count
);

    logic [aat_pkg::CNT_W-1:0] r_limit_cfg;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [aat_pkg::CNT_W-1:0] r_taken, n_taken;
    logic [aat_pkg::CNT_W-1:0] limit;
    logic [SUM_W-1:0]          sum_inc;
    logic [aat_pkg::CNT_W-1:0] taken_inc;
    logic                      accept;
    logic                      close;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_q_full;
    assign accept      = i_push && !i_q_full;

    // Zero window length behaves as one.
    assign limit     = (r_limit_cfg == '0) ? aat_pkg::CNT_W'(1) : r_limit_cfg;
    assign sum_inc   = r_sum + SUM_W'(i_sample);
    assign taken_inc = r_taken + aat_pkg::CNT_W'(1);
    assign close     = accept && (taken_inc != '0) && (taken_inc >= limit);

    assign o_q_push  = close;
    assign o_q_sum   = sum_inc;
    assign o_q_count = taken_inc;

    always_comb begin
        n_sum   = r_sum;
        n_taken = r_taken;
        if (close) begin
            n_sum   = '0;
            n_taken = '0;
        end else if (accept) begin
            n_sum   = sum_inc;
            n_taken = taken_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_cfg <= aat_pkg::CNT_RESET;
            r_sum       <= '0;
            r_taken     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit_cfg <= i_cfg_sample_count;
            end
            r_sum   <= n_sum;
            r_taken <= n_taken;
        end
    end

`include "adc_average_temperature_defines.svh"

    `AAT_ASSERT(a_taken_below_max, r_taken != '1, "window count reached its maximum")
    `AAT_ASSERT_NEXT(a_close_clears, close, (r_taken == '0) && (r_sum == '0), "window not cleared")

endmodule

// ===== sv/aat_queue.sv =====
// Short queue of closed windows between the front end and the divider.
module aat_queue #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_MAX);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`include "adc_average_temperature_defines.svh"

    `AAT_ASSERT(a_no_overflow, !(i_wr && o_full), "write into a full queue")
    `AAT_ASSERT(a_no_underflow, !(i_rd && o_empty), "read from an empty queue")

endmodule

// ===== sv/aat_back.sv =====
// Back end: iterative divide, fixed-point temperature and result register.
module aat_back #(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  logic [SUM_W-1:0]            i_q_sum,
    input  logic [aat_pkg::CNT_W-1:0]   i_q_count,
    output logic                        o_q_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [aat_pkg::AVG_W-1:0]   o_average,
    output logic signed [aat_pkg::TEMP_W-1:0] o_temp_centi
);

    localparam int K1_W    = aat_pkg::PROD_W - SAMPLE_BITS;
    localparam int BIT_W   = $clog2(SUM_W + 1);
    localparam int WHOLE_W = aat_pkg::ACC_W - aat_pkg::FRAC_W;
    localparam int CNT_W   = aat_pkg::CNT_W;
    localparam logic [63:0] K1_FULL =
        ((64'd3300000 * 64'd131072) / (64'd43 << SAMPLE_BITS) + 64'd1) / 64'd2;
    localparam logic [K1_W-1:0]    K1       = K1_FULL[K1_W-1:0];
    localparam logic [WHOLE_W-1:0] POS_LIM  = WHOLE_W'(32767);
    localparam logic [WHOLE_W-1:0] NEG_LIM  = WHOLE_W'(32768);
    localparam logic [aat_pkg::TEMP_W-1:0] TEMP_MAX = 16'h7FFF;
    localparam logic [aat_pkg::TEMP_W-1:0] TEMP_MIN = 16'h8000;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_MAG  = 6'b010000,
        S_OUT  = 6'b100000
    } t_back_state;

    t_back_state r_state, n_state;

    logic [SUM_W-1:0]                r_quot, n_quot;
    logic [CNT_W-1:0]                r_rem, n_rem;
    logic [CNT_W-1:0]                r_div, n_div;
    logic [BIT_W-1:0]                r_bits, n_bits;
    logic [aat_pkg::PROD_W-1:0]      r_prod;
    logic [aat_pkg::ACC_W-1:0]       r_acc;
    logic                            r_neg;
    logic [aat_pkg::ACC_W-1:0]       r_mag;
    logic                            r_out_valid;
    logic [aat_pkg::AVG_W-1:0]       r_out_avg;
    logic [aat_pkg::TEMP_W-1:0]      r_out_temp;

    logic [CNT_W:0]                  trial;
    logic                            fits;
    logic [WHOLE_W-1:0]              whole;
    logic [aat_pkg::TEMP_W-1:0]      temp_sat;
    logic                            out_free;
    logic                            load_out;

    assign out_free = !r_out_valid || i_pop;
    assign load_out = (r_state == S_OUT) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    // One quotient bit per cycle, restoring.
    assign trial = {r_rem, r_quot[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_div   = r_div;
        n_bits  = r_bits;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_quot  = i_q_sum;
                    n_div   = i_q_count;
                    n_rem   = '0;
                    n_bits  = BIT_W'(SUM_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = fits ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
                n_quot = {r_quot[SUM_W-2:0], fits};
                n_bits = r_bits - BIT_W'(1);
                if (r_bits == BIT_W'(1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_MAG;
            S_MAG:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign whole = r_mag[aat_pkg::ACC_W-1:aat_pkg::FRAC_W];

    always_comb begin
        if (!r_neg) begin
            temp_sat = (whole > POS_LIM) ? TEMP_MAX : whole[aat_pkg::TEMP_W-1:0];
        end else begin
            temp_sat = (whole > NEG_LIM) ? TEMP_MIN
                                         : (~whole[aat_pkg::TEMP_W-1:0]) + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_bits <= n_bits;
        if (r_state == S_MUL) begin
            r_prod <= aat_pkg::PROD_W'(r_quot[SAMPLE_BITS-1:0]) * aat_pkg::PROD_W'(K1);
        end
        if (r_state == S_ACC) begin
            r_acc <= aat_pkg::ACC_W'(aat_pkg::TEMP_K0) - aat_pkg::ACC_W'(r_prod);
        end
        if (r_state == S_MAG) begin
            r_neg <= r_acc[aat_pkg::ACC_W-1];
            r_mag <= r_acc[aat_pkg::ACC_W-1] ? (~r_acc) + aat_pkg::ACC_W'(1) : r_acc;
        end
        if (load_out) begin
            r_out_avg  <= r_quot[aat_pkg::AVG_W-1:0];
            r_out_temp <= temp_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_average    = r_out_avg;
    assign o_temp_centi = r_out_temp;

`include "adc_average_temperature_defines.svh"

    `AAT_ASSERT(a_divisor_nonzero, (r_state != S_DIV) || (r_div != '0), "divide by zero")
    `AAT_ASSERT_NEXT(a_result_held, r_out_valid && !i_pop, r_out_valid, "result lost")

endmodule

// ===== sv/adc_average_temperature.sv =====
// Top level of the oversampled temperature averaging block.
//
// Each transfer on the input side is one raw sensor reading. Readings are summed
// over a window of sample_count samples (a count of zero acts as one; lowering
// the count mid-window closes the window on the next reading). At the close of a
// window one result is produced: the truncated mean and the temperature in
// hundredths of a degree, saturated to signed 16 bits. The front end accepts one
// reading per cycle and stalls (full high) only while two closed windows already
// wait in the queue. In the back end each window is fetched from the queue, then
// passes through the bit-serial divider and the multiply, offset, magnitude and
// result stages in that order. The result register holds a finished result until
// it is popped while the next window is worked on. Write sample_count only while
// the block is idle; the write does not clear a window in progress.
module adc_average_temperature #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [aat_pkg::CNT_W-1:0]          i_cfg_sample_count,
    input  logic                               push,
    output logic                               full,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    output logic                               empty,
    input  logic                               pop,
    output logic [aat_pkg::AVG_W-1:0]          o_average,
    output logic signed [aat_pkg::TEMP_W-1:0]  o_temp_centi
);

    // Sum wide enough for a full window of full-scale readings.
    localparam int SUM_W = SAMPLE_BITS + aat_pkg::CNT_W;
    localparam int Q_W   = SUM_W + aat_pkg::CNT_W;

    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_empty;
    logic [SUM_W-1:0]          q_sum_in;
    logic [aat_pkg::CNT_W-1:0] q_count_in;
    logic [Q_W-1:0]            q_data_out;

    // Accumulate and close windows.
    aat_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_sample_count (i_cfg_sample_count),
        .o_cfg_ready        (o_cfg_ready),
        .i_push             (push),
        .i_sample           (i_sample),
        .o_full             (full),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_sum            (q_sum_in),
        .o_q_count          (q_count_in)
    );

    // Hold closed windows so the front end keeps taking readings.
    aat_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_data  ({q_sum_in, q_count_in}),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data_out)
    );

    // Divide, convert and present one result at a time.
    aat_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_sum      (q_data_out[Q_W-1:aat_pkg::CNT_W]),
        .i_q_count    (q_data_out[aat_pkg::CNT_W-1:0]),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_average    (o_average),
        .o_temp_centi (o_temp_centi)
    );

endmodule

// ===== bench/tb_adc_average_temperature.sv =====
// Self-checking testbench for the oversampled temperature averaging block.
module tb_adc_average_temperature;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 12;
    localparam int SUM_W       = SAMPLE_BITS + aat_pkg::CNT_W;

    // Allow the back end a full window time (fetch, divide, multiply, offset,
    // magnitude, result) twice over before the block counts as idle.
    localparam int SETTLE_CYCLES = 2 * (SAMPLE_BITS + 13);
    localparam int CYCLE_LIMIT   = 400000;

    // Q16 line constants: offset and slope of centi-degrees against the mean.
    localparam longint OFFSET_Q16 = (1537500 * 64'sd131072 / 43 + 1) / 2;
    localparam longint SLOPE_Q16  =
        (3300000 * 64'sd131072 / (43 * (64'sd1 << SAMPLE_BITS)) + 1) / 2;

    localparam longint CENTI_MAX = 32767;
    localparam longint CENTI_MIN = -32768;

    // Readings that matter: the saturation edges of the temperature line.
    localparam int HOT_EDGE  = 159;   // last mean that saturates high
    localparam int COLD_EDGE = 3658;  // first mean that saturates low

    typedef logic [SAMPLE_BITS-1:0]            t_sample;
    typedef logic [aat_pkg::CNT_W-1:0]         t_count;
    typedef logic [aat_pkg::AVG_W-1:0]         t_avg;
    typedef logic signed [aat_pkg::TEMP_W-1:0] t_centi;

    typedef struct packed {
        t_avg   average;
        t_centi temp_centi;
    } t_window_result;

    typedef enum logic [1:0] {
        DRAIN_STEADY,
        DRAIN_HALF,
        DRAIN_SPARSE,
        DRAIN_PATTERN
    } t_drain_mode;

    // -------------------------------------------------------------------------
    // Window predictor and result checker
    // -------------------------------------------------------------------------
    class window_checker;
        t_count                window_len   = aat_pkg::CNT_RESET;
        logic [SUM_W-1:0]      window_sum   = '0;
        t_count                window_taken = '0;
        t_window_result        awaited_windows[$];
        int                    mismatches   = 0;
        int                    windows_seen = 0;

        task report(input string msg);
            $display("[%0t] %s", $realtime, msg);
            mismatches++;
        endtask

        function void set_window(input t_count len);
            window_len = len;
        endfunction

        function int outstanding();
            return awaited_windows.size();
        endfunction

        // Fixed-point line, truncated toward zero, then clamped to 16 bits.
        function t_centi centi_from_mean(input t_avg mean);
            longint acc;
            longint whole;
            acc   = OFFSET_Q16 - longint'(mean) * SLOPE_Q16;
            whole = acc / 65536;
            if (whole > CENTI_MAX) whole = CENTI_MAX;
            if (whole < CENTI_MIN) whole = CENTI_MIN;
            return whole[aat_pkg::TEMP_W-1:0];
        endfunction

        // Accumulate one accepted reading; close the window when it is due.
        function void note_sample(input t_sample s);
            t_count         limit;
            t_window_result r;
            limit        = (window_len == '0) ? t_count'(1) : window_len;
            window_sum   = window_sum + SUM_W'(s);
            window_taken = window_taken + t_count'(1);
            if (window_taken == '0 || window_taken < limit) return;
            r.average    = t_avg'(window_sum / SUM_W'(window_taken));
            r.temp_centi = centi_from_mean(r.average);
            awaited_windows.push_back(r);
            window_sum   = '0;
            window_taken = '0;
        endfunction

        task check_result(input t_avg got_avg, input t_centi got_centi);
            t_window_result e;
            windows_seen++;
            if (awaited_windows.size() == 0) begin
                report($sformatf("unexpected result: average %0d temp %0d",
                                 got_avg, got_centi));
                return;
            end
            e = awaited_windows.pop_front();
            if (got_avg !== e.average)
                report($sformatf("average: got %0d, want %0d", got_avg, e.average));
            if (got_centi !== e.temp_centi)
                report($sformatf("temp_centi: got %0d, want %0d (average %0d)",
                                 got_centi, e.temp_centi, e.average));
        endtask
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset and block ports
    // -------------------------------------------------------------------------
    logic    i_clk              = 1'b0;
    logic    i_rst_n            = 1'b0;
    logic    i_cfg_valid        = 1'b0;
    logic    o_cfg_ready;
    t_count  i_cfg_sample_count = '0;
    logic    push               = 1'b0;
    logic    full;
    t_sample i_sample           = '0;
    logic    empty;
    logic    pop                = 1'b0;
    t_avg    o_average;
    t_centi  o_temp_centi;

    window_checker board = new();
    int            sent_total = 0;
    int            cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    adc_average_temperature #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_sample_count (i_cfg_sample_count),
        .push               (push),
        .full               (full),
        .i_sample           (i_sample),
        .empty              (empty),
        .pop                (pop),
        .o_average          (o_average),
        .o_temp_centi       (o_temp_centi)
    );

    // -------------------------------------------------------------------------
    // Result side: pop on a drifting stall pattern, check every transfer
    // -------------------------------------------------------------------------
    t_drain_mode drain_mode    = DRAIN_STEADY;
    int          drain_left    = 0;
    logic [15:0] drain_pattern = 16'hFFFF;

    always @(posedge i_clk) begin
        // Pick a fresh stall behaviour every so often; steady stretches included.
        if (drain_left == 0) begin
            drain_mode    <= t_drain_mode'($urandom_range(3));
            drain_left    <= $urandom_range(20, 200);
            drain_pattern <= 16'($urandom_range(16'hFFFF));
        end else begin
            drain_left    <= drain_left - 1;
            drain_pattern <= {drain_pattern[14:0], drain_pattern[15]};
        end
        case (drain_mode)
            DRAIN_STEADY:  pop <= 1'b1;
            DRAIN_HALF:    pop <= 1'($urandom_range(1));
            DRAIN_SPARSE:  pop <= ($urandom_range(7) == 0);
            DRAIN_PATTERN: pop <= drain_pattern[15];
            default:       pop <= 1'b1;
        endcase
    end

    // Values read here are the ones from before the edge, so each transfer is
    // seen exactly once.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result(o_average, o_temp_centi);
        end
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            board.report($sformatf("timeout, %0d windows still awaited",
                                   board.outstanding()));
            $display("end of test: mismatches");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Input side drivers
    // -------------------------------------------------------------------------

    // Offer one reading and hold it until the transfer happens.
    task automatic send_sample(input t_sample s);
        push     <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_sample(s);
        sent_total++;
    endtask

    // Drop push and idle for the requested span, with noise on the data lines.
    task automatic hold_off(input int n);
        if (n == 0) return;
        push     <= 1'b0;
        i_sample <= t_sample'($urandom_range((1 << SAMPLE_BITS) - 1));
        repeat (n) @(posedge i_clk);
    endtask

    // Wait until every awaited window has come out, then let the back end drain.
    task automatic settle();
        push     <= 1'b0;
        i_sample <= t_sample'($urandom_range((1 << SAMPLE_BITS) - 1));
        do @(posedge i_clk); while (board.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the window length once the block is idle.
    task automatic set_window_len(input t_count len);
        settle();
        i_cfg_valid        <= 1'b1;
        i_cfg_sample_count <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid        <= 1'b0;
        board.set_window(len);
    endtask

    // Readings biased towards the saturation edges and the rails.
    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_sample'($urandom_range(HOT_EDGE + 60, HOT_EDGE - 60));
            4, 5:    return t_sample'($urandom_range(COLD_EDGE + 60, COLD_EDGE - 60));
            default: return t_sample'($urandom_range((1 << SAMPLE_BITS) - 1));
        endcase
    endfunction

    // Window lengths: mostly short so results are plentiful, rails included.
    function automatic t_count pick_window_len();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return t_count'(1);
            3:       return t_count'($urandom_range(1, 255));
            default: return t_count'($urandom_range(2, 8));
        endcase
    endfunction

    // Send a run of readings in bursts; some runs go without any gaps.
    task automatic send_run(input int items, input bit full_scale);
        int burst_left;
        bit dense;
        dense      = ($urandom_range(3) == 0);
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < items; i++) begin
            if (!dense && burst_left == 0) begin
                hold_off($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            send_sample(full_scale ? t_sample'('1) : pick_sample());
            burst_left--;
        end
    endtask

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One window at the length the block wakes up with.
        send_run(int'(aat_pkg::CNT_RESET), 1'b0);

        // Single-sample windows: rails, low bit, midscale, alternating bits, both saturation edges.
        set_window_len(t_count'(1));
        send_sample('0);
        send_sample('1);
        send_sample(t_sample'(1));
        send_sample(t_sample'(1 << (SAMPLE_BITS - 1)));
        send_sample(t_sample'(12'h555));
        send_sample(t_sample'(12'hAAA));
        send_sample(t_sample'(HOT_EDGE));
        send_sample(t_sample'(HOT_EDGE + 1));
        send_sample(t_sample'(COLD_EDGE - 1));
        send_sample(t_sample'(COLD_EDGE));

        // A length of zero behaves as one.
        set_window_len('0);
        send_sample(t_sample'(7));
        send_sample(t_sample'(4088));

        // Lower the length mid-window: the next reading closes it and the mean
        // divides by what was actually taken.
        set_window_len(t_count'(10));
        repeat (5) send_sample(pick_sample());
        set_window_len(t_count'(3));
        send_sample(pick_sample());

        // Longest window at full scale: exercises the widest sum.
        set_window_len('1);
        send_run(255, 1'b1);

        // Random phases; the length is rewritten with windows left open.
        while (sent_total < 540 || board.windows_seen < 40) begin
            set_window_len(pick_window_len());
            send_run($urandom_range(8, 40), 1'b0);
        end

        settle();
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
